FILE: design/i2cm_pkg.sv
// Shared types and constants for the I2C master register interface.
// Used by the channel interfaces and the core; depends on nothing.
`default_nettype none

package i2cm_pkg;

   localparam int BYTE_W = 8;
   localparam int OP_W   = 3;

   // Control register bit positions.
   localparam int C_ACK = 0;
   localparam int C_STO = 1;
   localparam int C_STA = 2;
   localparam int C_ENI = 3;
   localparam int C_ES2 = 4;
   localparam int C_ES1 = 5;
   localparam int C_ESO = 6;
   localparam int C_PIN = 7;

   // Status register bit positions.
   localparam int S_BBN = 0;
   localparam int S_LRB = 3;
   localparam int S_PIN = 7;

   localparam logic [BYTE_W-1:0] ALL_ONES = 8'hff;

   // Start/stop request field {STA, STO} of a control write.
   localparam logic [1:0] SS_STA  = 2'b10;
   localparam logic [1:0] SS_STO  = 2'b01;
   localparam logic [1:0] SS_BOTH = 2'b11;

   typedef enum logic [OP_W-1:0] {
      OP_NONE      = 3'd0,
      OP_START     = 3'd1,
      OP_STOP      = 3'd2,
      OP_WRITE     = 3'd3,
      OP_READ      = 3'd4,
      OP_STOPSTART = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_STX  = 2'd1,
      MODE_MRX  = 2'd2,
      MODE_MTX  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      SEL_NONE,
      SEL_DATA,
      SEL_OWN,
      SEL_CTRL,
      SEL_STAT,
      SEL_CLOCK,
      SEL_VEC
   } sel_type;

endpackage

`default_nettype wire

FILE: design/i2cm_req_if.sv
// Request channel: one host register access with the partner's reply.
// Depends on i2cm_pkg for field widths.
`default_nettype none

interface i2cm_req_if;
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic                         a0;
   logic [i2cm_pkg::BYTE_W-1:0]  wdata;
   logic                         partner_ack;
   logic [i2cm_pkg::BYTE_W-1:0]  partner_data;

   modport source (output valid, func, a0, wdata, partner_ack, partner_data,
                   input ready);
   modport sink   (input valid, func, a0, wdata, partner_ack, partner_data,
                   output ready);
endinterface

`default_nettype wire

FILE: design/i2cm_rsp_if.sv
// Response channel: read data, issued bus operation and interrupt level.
// Depends on i2cm_pkg for field widths.
`default_nettype none

interface i2cm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [i2cm_pkg::BYTE_W-1:0]  rdata;
   logic [i2cm_pkg::OP_W-1:0]    i2c_op;
   logic [i2cm_pkg::BYTE_W-1:0]  i2c_byte;
   logic                         i2c_nack;
   logic                         irq;

   modport source (output valid, rdata, i2c_op, i2c_byte, i2c_nack, irq,
                   input ready);
   modport sink   (input valid, rdata, i2c_op, i2c_byte, i2c_nack, irq,
                   output ready);
endinterface

`default_nettype wire

FILE: design/i2c_master_register_interface_core.sv
// I2C master register interface core: register decode, bus actions, status.
// Depends on i2cm_pkg, i2cm_req_if and i2cm_rsp_if.
`default_nettype none

// Each request item is one host register access; the block answers each with
// exactly one response item. Items are taken into an input register, decoded
// and applied to the register file in a single pass, and the result lands in
// an output register, and one item is accepted every cycle as long as the
// response side keeps taking items. A stalled response holds the input
// register; req_ch.ready then follows rsp_ch.ready.
module i2c_master_register_interface_core (
   input  wire logic   clock,
   input  wire logic   reset,
   i2cm_req_if.sink    req_ch,
   i2cm_rsp_if.source  rsp_ch
);

   // Input register.
   logic                         in_valid_ff;
   logic                         in_func_ff;
   logic                         in_a0_ff;
   logic [i2cm_pkg::BYTE_W-1:0]  in_wdata_ff;
   logic                         in_ack_ff;
   logic [i2cm_pkg::BYTE_W-1:0]  in_pdata_ff;

   // Architectural state.
   logic [i2cm_pkg::BYTE_W-1:0]  data_ff, data_in;
   logic [i2cm_pkg::BYTE_W-1:0]  own_ff, own_in;
   logic [i2cm_pkg::BYTE_W-1:0]  ctrl_ff, ctrl_in;
   logic [i2cm_pkg::BYTE_W-1:0]  status_ff, status_in;
   logic [i2cm_pkg::BYTE_W-1:0]  clock_reg_ff, clock_reg_in;
   logic [i2cm_pkg::BYTE_W-1:0]  vector_ff, vector_in;
   i2cm_pkg::mode_type           mode_ff, mode_in;
   logic                         repeat_ff, repeat_in;
   logic                         bound_ff, bound_in;

   // Result register.
   logic                         out_valid_ff;
   logic [i2cm_pkg::BYTE_W-1:0]  rdata_ff, rdata_in;
   i2cm_pkg::op_type             op_ff, op_in;
   logic [i2cm_pkg::BYTE_W-1:0]  byte_ff, byte_in;
   logic                         nack_ff, nack_in;
   logic                         irq_ff, irq_in;

   i2cm_pkg::sel_type            sel;
   logic [2:0]                   es;
   logic [1:0]                   ss;
   logic                         start_now;
   logic                         advance;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   assign es = {ctrl_ff[i2cm_pkg::C_ESO], ctrl_ff[i2cm_pkg::C_ES1],
                ctrl_ff[i2cm_pkg::C_ES2]};
   assign ss = {in_wdata_ff[i2cm_pkg::C_STA], in_wdata_ff[i2cm_pkg::C_STO]};

   always_comb begin
      if (in_a0_ff) begin
         sel = (ctrl_ff[i2cm_pkg::C_ESO] && !in_func_ff) ? i2cm_pkg::SEL_STAT
                                                          : i2cm_pkg::SEL_CTRL;
      end else begin
         unique case (es)
            3'b000:                 sel = i2cm_pkg::SEL_OWN;
            3'b001, 3'b101:         sel = i2cm_pkg::SEL_VEC;
            3'b010:                 sel = i2cm_pkg::SEL_CLOCK;
            3'b100, 3'b110, 3'b111: sel = i2cm_pkg::SEL_DATA;
            default:                sel = i2cm_pkg::SEL_NONE;
         endcase
      end
   end

   always_comb begin
      data_in      = data_ff;
      own_in       = own_ff;
      ctrl_in      = ctrl_ff;
      status_in    = status_ff;
      clock_reg_in = clock_reg_ff;
      vector_in    = vector_ff;
      mode_in      = mode_ff;
      repeat_in    = repeat_ff;
      bound_in     = bound_ff;
      rdata_in     = '0;
      op_in        = i2cm_pkg::OP_NONE;
      byte_in      = '0;
      nack_in      = 1'b0;
      start_now    = 1'b0;

      if (in_func_ff) begin
         unique case (sel)
            i2cm_pkg::SEL_DATA: begin
               data_in = in_wdata_ff;
               byte_in = in_wdata_ff;
               if (repeat_ff) begin
                  repeat_in = 1'b0;
                  op_in     = i2cm_pkg::OP_START;
                  start_now = 1'b1;
               end else begin
                  op_in = i2cm_pkg::OP_WRITE;
                  status_in[i2cm_pkg::S_LRB] = !(bound_ff && in_ack_ff);
               end
               status_in[i2cm_pkg::S_PIN] = 1'b0;
            end
            i2cm_pkg::SEL_OWN:   own_in       = in_wdata_ff;
            i2cm_pkg::SEL_CLOCK: clock_reg_in = in_wdata_ff;
            i2cm_pkg::SEL_VEC:   vector_in    = in_wdata_ff;
            i2cm_pkg::SEL_CTRL: begin
               ctrl_in = in_wdata_ff;
               if (in_wdata_ff[i2cm_pkg::C_PIN]) begin
                  status_in = '0;
                  status_in[i2cm_pkg::S_PIN] = 1'b1;
                  status_in[i2cm_pkg::S_BBN] = 1'b1;
                  ctrl_in[i2cm_pkg::C_PIN]   = 1'b0;
               end
               if (mode_ff == i2cm_pkg::MODE_IDLE) begin
                  if (ss == i2cm_pkg::SS_STA) begin
                     op_in     = i2cm_pkg::OP_START;
                     byte_in   = data_ff;
                     start_now = 1'b1;
                  end
               end else if (mode_ff == i2cm_pkg::MODE_MRX ||
                            mode_ff == i2cm_pkg::MODE_MTX) begin
                  priority if (ss == i2cm_pkg::SS_STA) begin
                     // A start while already master only arms a repeated start,
                     // and only in transmit mode.
                     if (mode_ff == i2cm_pkg::MODE_MTX) begin
                        repeat_in = 1'b1;
                        status_in[i2cm_pkg::S_PIN] = 1'b0;
                     end
                  end else if (ss == i2cm_pkg::SS_STO) begin
                     op_in    = i2cm_pkg::OP_STOP;
                     bound_in = 1'b0;
                     mode_in  = i2cm_pkg::MODE_IDLE;
                     status_in[i2cm_pkg::S_PIN] = 1'b1;
                  end else if (ss == i2cm_pkg::SS_BOTH) begin
                     op_in     = i2cm_pkg::OP_STOPSTART;
                     byte_in   = data_ff;
                     bound_in  = 1'b0;
                     mode_in   = i2cm_pkg::MODE_IDLE;
                     start_now = 1'b1;
                  end else begin
                     op_in = i2cm_pkg::OP_NONE;
                  end
               end
            end
            default: ;
         endcase
      end else begin
         unique case (sel)
            i2cm_pkg::SEL_NONE:  rdata_in = i2cm_pkg::ALL_ONES;
            i2cm_pkg::SEL_OWN:   rdata_in = own_ff;
            i2cm_pkg::SEL_CTRL:  rdata_in = ctrl_ff;
            i2cm_pkg::SEL_STAT:  rdata_in = status_ff;
            i2cm_pkg::SEL_CLOCK: rdata_in = clock_reg_ff;
            i2cm_pkg::SEL_VEC:   rdata_in = vector_ff;
            default: begin
               // Return the byte held now, then fetch the next one.
               rdata_in = data_ff;
               op_in    = i2cm_pkg::OP_READ;
               nack_in  = !ctrl_ff[i2cm_pkg::C_ACK];
               if (bound_ff && in_ack_ff) begin
                  status_in[i2cm_pkg::S_LRB] = 1'b0;
                  data_in = in_pdata_ff;
               end else begin
                  status_in[i2cm_pkg::S_LRB] = 1'b1;
                  data_in = i2cm_pkg::ALL_ONES;
               end
               status_in[i2cm_pkg::S_PIN] = 1'b0;
            end
         endcase
      end

      // An acknowledged start binds the partner and enters master mode by the
      // read/write bit of the address byte.
      if (start_now) begin
         if (in_ack_ff) begin
            bound_in = 1'b1;
            mode_in  = data_in[0] ? i2cm_pkg::MODE_MRX : i2cm_pkg::MODE_MTX;
         end else begin
            status_in[i2cm_pkg::S_LRB] = 1'b1;
         end
         status_in[i2cm_pkg::S_PIN] = 1'b0;
      end

      irq_in = !status_in[i2cm_pkg::S_PIN] && ctrl_in[i2cm_pkg::C_ENI];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_func_ff  <= req_ch.func;
         in_a0_ff    <= req_ch.a0;
         in_wdata_ff <= req_ch.wdata;
         in_ack_ff   <= req_ch.partner_ack;
         in_pdata_ff <= req_ch.partner_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff      <= '0;
         own_ff       <= '0;
         ctrl_ff      <= '0;
         status_ff    <= '0;
         clock_reg_ff <= '0;
         vector_ff    <= '0;
         mode_ff      <= i2cm_pkg::MODE_IDLE;
         repeat_ff    <= 1'b0;
         bound_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            data_ff      <= data_in;
            own_ff       <= own_in;
            ctrl_ff      <= ctrl_in;
            status_ff    <= status_in;
            clock_reg_ff <= clock_reg_in;
            vector_ff    <= vector_in;
            mode_ff      <= mode_in;
            repeat_ff    <= repeat_in;
            bound_ff     <= bound_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rdata_ff <= rdata_in;
         op_ff    <= op_in;
         byte_ff  <= byte_in;
         nack_ff  <= nack_in;
         irq_ff   <= irq_in;
      end
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.rdata    = rdata_ff;
   assign rsp_ch.i2c_op   = op_ff;
   assign rsp_ch.i2c_byte = byte_ff;
   assign rsp_ch.i2c_nack = nack_ff;
   assign rsp_ch.irq      = irq_ff;

   // Master mode is only ever entered by an acknowledged start, which binds.
   a_master_bound: assert property (@(posedge clock) disable iff (reset)
      mode_ff != i2cm_pkg::MODE_IDLE |-> bound_ff)
      else $error("bus mode is active without a bound partner");

   a_no_slave_tx: assert property (@(posedge clock) disable iff (reset)
      mode_ff != i2cm_pkg::MODE_STX)
      else $error("slave transmit mode was entered");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (op_ff == i2cm_pkg::OP_NONE || op_ff == i2cm_pkg::OP_STOP ||
                       op_ff == i2cm_pkg::OP_READ) |-> byte_ff == '0)
      else $error("bus byte reported for an operation that sends none");

   a_nack_read_only: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && op_ff != i2cm_pkg::OP_READ |-> !nack_ff)
      else $error("nack reported for an operation other than a read");

   a_write_rdata: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && op_ff != i2cm_pkg::OP_NONE && op_ff != i2cm_pkg::OP_READ
      |-> rdata_ff == '0)
      else $error("read data nonzero on a write item");

endmodule

`default_nettype wire

FILE: dv/i2c_master_register_interface_core_tb.sv
// Self-checking testbench for the I2C master register interface core.
// Depends on i2cm_pkg, i2cm_req_if, i2cm_rsp_if and the core itself.
`timescale 1ns / 1ps

module i2c_master_register_interface_core_tb;

   localparam int ACCESS_TARGET = 1300;
   localparam int CALM_TAIL     = 150;  // last items run with no idling
   localparam int HOLD_AT       = 300;  // responses seen before the long hold
   localparam int HOLD_CYCLES   = 200;

   localparam logic FN_READ  = 1'b0;
   localparam logic FN_WRITE = 1'b1;
   localparam logic A0_DATA  = 1'b0;
   localparam logic A0_CTRL  = 1'b1;

   localparam logic [7:0] CB_ACK = 8'h01 << i2cm_pkg::C_ACK;
   localparam logic [7:0] CB_STO = 8'h01 << i2cm_pkg::C_STO;
   localparam logic [7:0] CB_STA = 8'h01 << i2cm_pkg::C_STA;
   localparam logic [7:0] CB_ENI = 8'h01 << i2cm_pkg::C_ENI;
   localparam logic [7:0] CB_ES2 = 8'h01 << i2cm_pkg::C_ES2;
   localparam logic [7:0] CB_ES1 = 8'h01 << i2cm_pkg::C_ES1;
   localparam logic [7:0] CB_ESO = 8'h01 << i2cm_pkg::C_ESO;
   localparam logic [7:0] CB_PIN = 8'h01 << i2cm_pkg::C_PIN;

   typedef struct packed {
      logic       func;
      logic       a0;
      logic [7:0] wdata;
      logic       partner_ack;
      logic [7:0] partner_data;
   } access_type;

   typedef struct packed {
      logic [7:0]       rdata;
      i2cm_pkg::op_type op;
      logic [7:0]       bus_byte;
      logic             nack;
      logic             irq;
   } rsp_type;

   logic clock = 1'b0;
   logic reset;

   i2cm_req_if req_ch();
   i2cm_rsp_if rsp_ch();

   i2c_master_register_interface_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   access_type pend_accesses[$];
   rsp_type    predicted_rsp[$];

   int errors = 0;
   int rsp_seen = 0;
   int op_count[6];
   int irq_count = 0;
   logic req_taken = 1'b0;
   int gap_left = 0;
   int stall_left = 0;
   int hold_left = 0;
   logic pressure_done = 1'b0;

   // Predicted controller state.
   logic [7:0] data_q = '0, own_q = '0, ctrl_q = '0, status_q = '0, clock_q = '0,
               vector_q = '0;
   i2cm_pkg::mode_type mode_q = i2cm_pkg::MODE_IDLE;
   logic       rep_pending = 1'b0, bound = 1'b0;

   function automatic i2cm_pkg::sel_type decode_reg(logic a0, logic rd);
      logic [2:0] es;
      es = {ctrl_q[i2cm_pkg::C_ESO], ctrl_q[i2cm_pkg::C_ES1], ctrl_q[i2cm_pkg::C_ES2]};
      if (a0)
         return (ctrl_q[i2cm_pkg::C_ESO] && rd) ? i2cm_pkg::SEL_STAT : i2cm_pkg::SEL_CTRL;
      case (es)
         3'b000: return i2cm_pkg::SEL_OWN;
         3'b001: return i2cm_pkg::SEL_VEC;
         3'b010: return i2cm_pkg::SEL_CLOCK;
         3'b100, 3'b110, 3'b111: return i2cm_pkg::SEL_DATA;
         3'b101: return i2cm_pkg::SEL_VEC;
         default: return i2cm_pkg::SEL_NONE;
      endcase
   endfunction

   task automatic bus_start(input logic ack);
      // An acknowledged start binds a partner; a start without the ack sets LRB instead.
      if (ack)
         bound = 1'b1;
      if (!ack)
         status_q[i2cm_pkg::S_LRB] = 1'b1;
      else
         mode_q = data_q[0] ? i2cm_pkg::MODE_MRX : i2cm_pkg::MODE_MTX;
      status_q[i2cm_pkg::S_PIN] = 1'b0;
   endtask

   task automatic bus_stop();
      bound = 1'b0;
      mode_q = i2cm_pkg::MODE_IDLE;
      status_q[i2cm_pkg::S_PIN] = 1'b1;
   endtask

   task automatic apply_access(input access_type it, output rsp_type r);
      i2cm_pkg::sel_type sel;
      logic [1:0] ss;
      sel = decode_reg(it.a0, !it.func);
      r = '0;
      r.op = i2cm_pkg::OP_NONE;
      if (it.func) begin
         case (sel)
            i2cm_pkg::SEL_DATA: begin
               data_q = it.wdata;
               r.bus_byte = it.wdata;
               if (rep_pending) begin
                  rep_pending = 1'b0;
                  r.op = i2cm_pkg::OP_START;
                  bus_start(it.partner_ack);
               end else begin
                  r.op = i2cm_pkg::OP_WRITE;
                  status_q[i2cm_pkg::S_LRB] = !(bound && it.partner_ack);
               end
               status_q[i2cm_pkg::S_PIN] = 1'b0;
            end
            i2cm_pkg::SEL_OWN: own_q = it.wdata;
            i2cm_pkg::SEL_CLOCK: clock_q = it.wdata;
            i2cm_pkg::SEL_VEC: vector_q = it.wdata;
            i2cm_pkg::SEL_CTRL: begin
               ss = {it.wdata[i2cm_pkg::C_STA], it.wdata[i2cm_pkg::C_STO]};
               ctrl_q = it.wdata;
               if (it.wdata[i2cm_pkg::C_PIN]) begin
                  status_q = '0;
                  status_q[i2cm_pkg::S_PIN] = 1'b1;
                  status_q[i2cm_pkg::S_BBN] = 1'b1;
                  ctrl_q[i2cm_pkg::C_PIN] = 1'b0;
               end
               if (mode_q == i2cm_pkg::MODE_IDLE) begin
                  if (ss == i2cm_pkg::SS_STA) begin
                     r.op = i2cm_pkg::OP_START;
                     r.bus_byte = data_q;
                     bus_start(it.partner_ack);
                  end
               end else if (mode_q == i2cm_pkg::MODE_MRX ||
                            mode_q == i2cm_pkg::MODE_MTX) begin
                  if (ss == i2cm_pkg::SS_STA) begin
                     // A repeated start is only armed while transmitting.
                     if (mode_q == i2cm_pkg::MODE_MTX) begin
                        rep_pending = 1'b1;
                        status_q[i2cm_pkg::S_PIN] = 1'b0;
                     end
                  end else if (ss == i2cm_pkg::SS_STO) begin
                     r.op = i2cm_pkg::OP_STOP;
                     bus_stop();
                  end else if (ss == i2cm_pkg::SS_BOTH) begin
                     r.op = i2cm_pkg::OP_STOPSTART;
                     r.bus_byte = data_q;
                     bus_stop();
                     bus_start(it.partner_ack);
                  end
               end
            end
            default: ;
         endcase
      end else begin
         case (sel)
            i2cm_pkg::SEL_NONE: r.rdata = i2cm_pkg::ALL_ONES;
            i2cm_pkg::SEL_OWN: r.rdata = own_q;
            i2cm_pkg::SEL_CTRL: r.rdata = ctrl_q;
            i2cm_pkg::SEL_STAT: r.rdata = status_q;
            i2cm_pkg::SEL_CLOCK: r.rdata = clock_q;
            i2cm_pkg::SEL_VEC: r.rdata = vector_q;
            default: begin
               r.rdata = data_q;
               r.op = i2cm_pkg::OP_READ;
               r.nack = !ctrl_q[i2cm_pkg::C_ACK];
               if (bound && it.partner_ack) begin
                  status_q[i2cm_pkg::S_LRB] = 1'b0;
                  data_q = it.partner_data;
               end else begin
                  status_q[i2cm_pkg::S_LRB] = 1'b1;
                  data_q = i2cm_pkg::ALL_ONES;
               end
               status_q[i2cm_pkg::S_PIN] = 1'b0;
            end
         endcase
      end
      r.irq = !status_q[i2cm_pkg::S_PIN] && ctrl_q[i2cm_pkg::C_ENI];
   endtask

   function automatic logic field_ok(string name, logic [7:0] expv, logic [7:0] actv);
      if (expv === actv)
         return 1'b1;
      $display("%0t: %s mismatch: expected %02h, actual %02h", $time, name, expv, actv);
      return 1'b0;
   endfunction

   // Prediction on acceptance, then comparison of any response taken at this edge.
   always @(posedge clock) begin
      access_type it;
      rsp_type    r;
      logic       ok;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            it = '{req_ch.func, req_ch.a0, req_ch.wdata, req_ch.partner_ack,
                   req_ch.partner_data};
            apply_access(it, r);
            predicted_rsp.push_back(r);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_seen <= rsp_seen + 1;
            if (predicted_rsp.size() == 0) begin
               $display("%0t: response with no access outstanding: rdata %02h op %0d",
                        $time, rsp_ch.rdata, rsp_ch.i2c_op);
               errors++;
            end else begin
               r = predicted_rsp.pop_front();
               ok = field_ok("rdata", r.rdata, rsp_ch.rdata);
               ok &= field_ok("i2c_op", 8'(r.op), 8'(rsp_ch.i2c_op));
               ok &= field_ok("i2c_byte", r.bus_byte, rsp_ch.i2c_byte);
               ok &= field_ok("i2c_nack", 8'(r.nack), 8'(rsp_ch.i2c_nack));
               ok &= field_ok("irq", 8'(r.irq), 8'(rsp_ch.irq));
               if (!ok)
                  errors++;
               op_count[int'(r.op)]++;
               if (r.irq)
                  irq_count++;
            end
         end
      end
   end

   // Request driver.
   always @(negedge clock) begin
      access_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_ch.valid <= 1'b0;
         end else if (pend_accesses.size() == 0) begin
            req_ch.valid <= 1'b0;
         end else if (pend_accesses.size() >= CALM_TAIL && $urandom_range(0, 11) == 0) begin
            gap_left <= $urandom_range(0, 17);
            req_ch.valid <= 1'b0;
         end else begin
            nxt = pend_accesses.pop_front();
            req_ch.func <= nxt.func;
            req_ch.a0 <= nxt.a0;
            req_ch.wdata <= nxt.wdata;
            req_ch.partner_ack <= nxt.partner_ack;
            req_ch.partner_data <= nxt.partner_data;
            req_ch.valid <= 1'b1;
         end
      end
   end

   // Response ready: random stalls plus one long hold that backs up the input.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!pressure_done && rsp_seen >= HOLD_AT) begin
         pressure_done <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (pend_accesses.size() >= CALM_TAIL && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 17);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic likely_ack();
      return $urandom_range(0, 7) != 0;
   endfunction

   task automatic queue_access(input logic fn, input logic a0, input logic [7:0] wd,
                               input logic ack, input logic [7:0] pd);
      pend_accesses.push_back('{fn, a0, wd, ack, pd});
   endtask

   // Data-phase accesses of one transfer, mostly in the addressed direction.
   task automatic queue_payload(input logic rw);
      int n;
      logic rd;
      n = $urandom_range(1, 6);
      repeat (n) begin
         rd = ($urandom_range(0, 9) == 0) ? !rw : rw;
         if ($urandom_range(0, 7) == 0)
            queue_access(FN_READ, A0_CTRL, rand_byte(), likely_ack(), rand_byte());
         else
            queue_access(rd ? FN_READ : FN_WRITE, A0_DATA, rand_byte(), likely_ack(),
                         rand_byte());
      end
   endtask

   // A well-formed bus transfer with random content: optional setup, address, start, data,
   // an optional repeated start, an optional stop-start, and a closing stop.
   task automatic queue_transfer();
      logic [7:0] base;
      logic rw;
      base = CB_ESO;
      if ($urandom_range(0, 1)) base |= CB_ENI;
      if ($urandom_range(0, 1)) base |= CB_ACK;
      if ($urandom_range(0, 3) == 0) base |= $urandom_range(0, 1) ? CB_ES1 : (CB_ES1 | CB_ES2);
      if ($urandom_range(0, 1))
         queue_access(FN_WRITE, A0_CTRL, base | CB_PIN, likely_ack(), rand_byte());
      rw = 1'($urandom_range(0, 1));
      queue_access(FN_WRITE, A0_DATA, {7'($urandom_range(0, 127)), rw}, likely_ack(),
                   rand_byte());
      queue_access(FN_WRITE, A0_CTRL, base | CB_STA, likely_ack(), rand_byte());
      queue_payload(rw);
      if ($urandom_range(0, 3) == 0) begin
         rw = 1'($urandom_range(0, 1));
         queue_access(FN_WRITE, A0_CTRL, base | CB_STA, likely_ack(), rand_byte());
         queue_access(FN_WRITE, A0_DATA, {7'($urandom_range(0, 127)), rw}, likely_ack(),
                      rand_byte());
         queue_payload(rw);
      end
      if ($urandom_range(0, 3) == 0) begin
         queue_access(FN_WRITE, A0_CTRL, base | CB_STA | CB_STO, likely_ack(), rand_byte());
         queue_payload(1'($urandom_range(0, 1)));
      end
      queue_access(FN_WRITE, A0_CTRL, base | CB_STO, likely_ack(), rand_byte());
   endtask

   task automatic queue_directed();
      queue_access(FN_READ, A0_CTRL, 8'h00, 1'b0, 8'h00);
      queue_access(FN_READ, A0_DATA, 8'hff, 1'b1, 8'hff);
      queue_access(FN_WRITE, A0_DATA, 8'hff, 1'b0, 8'h00);
      queue_access(FN_WRITE, A0_DATA, 8'ha5, 1'b1, 8'h00);
      queue_access(FN_READ, A0_DATA, 8'h00, 1'b0, 8'h00);
      queue_access(FN_WRITE, A0_CTRL, CB_ES2, 1'b0, 8'h00);
      queue_access(FN_WRITE, A0_DATA, 8'hff, 1'b0, 8'h00);
      queue_access(FN_READ, A0_DATA, 8'h00, 1'b0, 8'h00);
      queue_access(FN_WRITE, A0_CTRL, CB_ES1, 1'b0, 8'h00);
      queue_access(FN_WRITE, A0_DATA, 8'h5a, 1'b0, 8'h00);
      queue_access(FN_READ, A0_DATA, 8'h00, 1'b0, 8'h00);
      // Undecoded register: writes vanish and reads give all ones.
      queue_access(FN_WRITE, A0_CTRL, CB_ES1 | CB_ES2, 1'b0, 8'h00);
      queue_access(FN_WRITE, A0_DATA, 8'h12, 1'b0, 8'h00);
      queue_access(FN_READ, A0_DATA, 8'h00, 1'b0, 8'h00);
      queue_access(FN_WRITE, A0_CTRL, CB_PIN | CB_ESO | CB_ENI | CB_ACK, 1'b0, 8'h00);
      queue_access(FN_READ, A0_CTRL, 8'h00, 1'b0, 8'h00);
      // Byte sent with no partner bound is never acknowledged.
      queue_access(FN_WRITE, A0_DATA, 8'ha0, 1'b1, 8'h00);
      queue_access(FN_WRITE, A0_CTRL, CB_ESO | CB_ENI | CB_STA | CB_ACK, 1'b1, 8'h00);
      queue_access(FN_WRITE, A0_DATA, 8'h55, 1'b1, 8'h00);
      queue_access(FN_WRITE, A0_DATA, 8'h00, 1'b0, 8'h00);
      // Repeated start in transmit mode, then a read transfer.
      queue_access(FN_WRITE, A0_CTRL, CB_ESO | CB_ENI | CB_STA | CB_ACK, 1'b1, 8'h00);
      queue_access(FN_WRITE, A0_DATA, 8'ha1, 1'b1, 8'h00);
      queue_access(FN_READ, A0_DATA, 8'h00, 1'b1, 8'h3c);
      queue_access(FN_WRITE, A0_CTRL, CB_ESO | CB_ENI | CB_STA, 1'b1, 8'h00);
      queue_access(FN_READ, A0_DATA, 8'h00, 1'b0, 8'h77);
      queue_access(FN_READ, A0_DATA, 8'h00, 1'b1, 8'hff);
      queue_access(FN_WRITE, A0_CTRL, CB_ESO | CB_STA | CB_STO, 1'b1, 8'h00);
      queue_access(FN_WRITE, A0_CTRL, CB_ESO | CB_STO, 1'b0, 8'h00);
      queue_access(FN_WRITE, A0_CTRL, CB_ESO | CB_STO, 1'b0, 8'h00);
      queue_access(FN_WRITE, A0_CTRL, CB_ESO | CB_STA, 1'b0, 8'h00);
      queue_access(FN_WRITE, A0_CTRL, 8'hff, 1'b1, 8'h00);
      queue_access(FN_READ, A0_DATA, 8'h00, 1'b1, 8'h81);
      queue_access(FN_WRITE, A0_CTRL, CB_ESO | CB_ES2, 1'b0, 8'h00);
      queue_access(FN_READ, A0_DATA, 8'h00, 1'b0, 8'h00);
   endtask

   initial begin
      logic [7:0] sel_bits;
      reset = 1'b1;

      queue_directed();
      while (pend_accesses.size() < ACCESS_TARGET) begin
         case ($urandom_range(0, 9))
            7, 8: repeat ($urandom_range(1, 4))
               queue_access(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand_byte(),
                            1'($urandom_range(0, 1)), rand_byte());
            9: begin
               // Side registers reached with ESO clear.
               sel_bits = 8'($urandom_range(0, 3) << i2cm_pkg::C_ES2);
               if ($urandom_range(0, 1)) sel_bits |= CB_ENI;
               queue_access(FN_WRITE, A0_CTRL, sel_bits, 1'b0, rand_byte());
               queue_access(FN_WRITE, A0_DATA, rand_byte(), 1'($urandom_range(0, 1)),
                            rand_byte());
               queue_access(FN_READ, A0_DATA, rand_byte(), 1'($urandom_range(0, 1)),
                            rand_byte());
               queue_access(FN_READ, A0_CTRL, rand_byte(), 1'($urandom_range(0, 1)),
                            rand_byte());
            end
            default: queue_transfer();
         endcase
      end

      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pend_accesses.size() != 0 || req_ch.valid) @(posedge clock);
      while (predicted_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Ran %0d host accesses: %0d starts, %0d stop-starts, %0d stops,",
               rsp_seen, op_count[i2cm_pkg::OP_START], op_count[i2cm_pkg::OP_STOPSTART],
               op_count[i2cm_pkg::OP_STOP]);
      $display("%0d byte writes, %0d byte reads and %0d responses with the interrupt raised.",
               op_count[i2cm_pkg::OP_WRITE], op_count[i2cm_pkg::OP_READ], irq_count);
      if (errors == 0 && predicted_rsp.size() == 0)
         $display("i2c_master_register_interface_core_tb: done, clean");
      else
         $display("i2c_master_register_interface_core_tb: done, errors");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d accesses unsent and %0d responses outstanding.",
               pend_accesses.size(), predicted_rsp.size());
      $display("i2c_master_register_interface_core_tb: done, errors");
      $finish;
   end

endmodule

FILE: files.f
design/i2cm_pkg.sv
design/i2cm_req_if.sv
design/i2cm_rsp_if.sv
design/i2c_master_register_interface_core.sv
dv/i2c_master_register_interface_core_tb.sv
